@@ rtl/gcb_pkg.sv @@
// gcb_pkg: shared constants and elaboration-time table functions for the bearing block
// no dependencies; used by gcb_to_angle, gcb_cordic_rot and great_circle_bearing_deg

package gcb_pkg;

  localparam int VEC_FRAC = 30;
  localparam int WIDE_FRAC = 62;
  localparam int UPD_SHIFT = 7;         // units per degree = 78125 * 2^7
  localparam int UPD_ODD = 78125;
  localparam int RECIP_SHIFT = 32;      // fraction bits of the unit conversion reciprocal
  localparam int COORD_W = 32;          // coordinates widened to one signed width
  localparam int CS_W = 34;             // sine / cosine, 30 fraction bits
  localparam int VEC_W = 35;            // vectoring x / y, 30 fraction bits

  // shift-subtract division, used only while building constants
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(2^(frac - 7 + 32) / 78125), reciprocal used by the unit conversion
  function automatic longint unsigned recip_units(input int frac);
    logic [127:0] n;
    logic [127:0] r;
    logic [127:0] q;
    n = 128'(1) << (frac - UPD_SHIFT + RECIP_SHIFT);
    q = '0;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      r = {r[126:0], n[b]};
      if (r >= 128'(UPD_ODD)) begin
        r = r - 128'(UPD_ODD);
        q[b] = 1'b1;
      end
    end
    return q[63:0];
  endfunction

  // arctangent of 1/n scaled by 2^62, series sum
  function automatic longint unsigned atan_inv(input longint unsigned n);
    longint unsigned p;
    longint unsigned sum;
    longint unsigned k;
    longint unsigned term;
    p = udiv64(longint'(1) << WIDE_FRAC, n);
    sum = 0;
    k = 0;
    while (p != 0) begin
      term = udiv64(p, 2 * k + 1);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      p = udiv64(p, n * n);
      k = k + 1;
    end
    return sum;
  endfunction

  // arctangent of 2^-i scaled by 2^62
  function automatic longint unsigned atan_pow2(input int i);
    longint unsigned sum;
    longint unsigned k;
    longint unsigned term;
    int e;
    sum = 0;
    k = 0;
    e = WIDE_FRAC - i;
    while (e >= 0) begin
      term = udiv64(longint'(1) << e, 2 * k + 1);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      k = k + 1;
      e = e - 2 * i;
    end
    return sum;
  endfunction

  // step angle of cordic stage i in degrees with frac fraction bits, rounded down
  function automatic longint step_angle(input int i, input int frac);
    longint unsigned qp;
    longint unsigned r;
    longint unsigned q;
    if (i == 0) return longint'(45) << frac;
    qp = 4 * atan_inv(5) - atan_inv(239);
    r = atan_pow2(i);
    q = 0;
    for (int b = 0; b < frac; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= qp) begin
        r = r - qp;
        q = q | 1;
      end
    end
    return longint'(q * 45);
  endfunction

  // reciprocal of the cordic gain, 30 fraction bits
  function automatic longint gain_k(input int stages);
    longint x;
    longint y;
    longint nx;
    longint ny;
    x = longint'(1) << VEC_FRAC;
    y = 0;
    for (int i = 0; i < stages; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
      end
      x = nx;
      y = ny;
    end
    if (x > 0) return longint'(udiv64(longint'(1) << (2 * VEC_FRAC), x));
    return 0;
  endfunction

  // fixed-point product, floor shift by 30
  function automatic logic signed [CS_W-1:0] fmul(input logic signed [CS_W-1:0] a,
                                                  input logic signed [CS_W-1:0] b);
    logic signed [2*CS_W-1:0] p;
    p = a * b;
    return CS_W'(p >>> VEC_FRAC);
  endfunction

endpackage

@@ rtl/gcb_to_angle.sv @@
// gcb_to_angle: pipelined conversion of 1e-7 degree units to fixed-point degrees
// reciprocal multiplication with one correction step, six register stages; uses gcb_pkg

module gcb_to_angle #(
  parameter int ANGLE_FRACTION_BITS = 28,
  parameter int AW = 39
) (
  input  logic                                   clk,
  input  logic                                   ce,
  input  logic signed [gcb_pkg::COORD_W-1:0]     v,
  output logic signed [AW-1:0]                   a
);

  localparam int MW = gcb_pkg::COORD_W;
  localparam int SH = ANGLE_FRACTION_BITS - gcb_pkg::UPD_SHIFT;
  localparam int PW = AW + 17;
  localparam longint unsigned RECIP = gcb_pkg::recip_units(ANGLE_FRACTION_BITS);
  localparam logic [31:0] RECIP_LO = RECIP[31:0];
  localparam logic [31:0] RECIP_HI = RECIP[63:32];
  localparam logic [PW-1:0] ODD = PW'(gcb_pkg::UPD_ODD);

  logic [MW-1:0]        mag_r;
  logic [MW-1:0]        mag2_r;
  logic [MW-1:0]        mag3_r;
  logic                 sgn1_r;
  logic                 sgn2_r;
  logic                 sgn3_r;
  logic                 sgn4_r;
  logic                 sgn5_r;
  logic [63:0]          plo_r;
  logic [63:0]          phi_r;
  logic [AW-1:0]        est_r;
  logic [AW-1:0]        est4_r;
  logic [PW-1:0]        prod_r;
  logic [PW-1:0]        num4_r;
  logic [AW-1:0]        q_r;
  logic signed [AW-1:0] a_r;

  // estimate is the true quotient or one below it, a single compare fixes it
  always_ff @(posedge clk) begin
    if (ce) begin
      mag_r  <= v[MW-1] ? MW'(-v) : MW'(v);
      sgn1_r <= v[MW-1];

      plo_r  <= 64'(mag_r) * 64'(RECIP_LO);
      phi_r  <= 64'(mag_r) * 64'(RECIP_HI);
      mag2_r <= mag_r;
      sgn2_r <= sgn1_r;

      est_r  <= AW'(phi_r + (plo_r >> 32));
      mag3_r <= mag2_r;
      sgn3_r <= sgn2_r;

      prod_r <= PW'(est_r) * ODD;
      num4_r <= PW'(mag3_r) << SH;
      est4_r <= est_r;
      sgn4_r <= sgn3_r;

      q_r    <= ((num4_r - prod_r) >= ODD) ? est4_r + AW'(1) : est4_r;
      sgn5_r <= sgn4_r;

      a_r    <= sgn5_r ? -$signed(q_r) : $signed(q_r);
    end
  end

  assign a = a_r;

endmodule

@@ rtl/gcb_cordic_rot.sv @@
// gcb_cordic_rot: pipelined rotation cordic giving sine and cosine of an angle in (-180, 180]
// fold stage, one register per cordic stage, output stage; uses gcb_pkg

module gcb_cordic_rot #(
  parameter int CORDIC_STAGES = 24,
  parameter int ANGLE_FRACTION_BITS = 28,
  parameter int AW = 39
) (
  input  logic                               clk,
  input  logic                               ce,
  input  logic signed [AW-1:0]               ang,
  output logic signed [gcb_pkg::CS_W-1:0]    sin_o,
  output logic signed [gcb_pkg::CS_W-1:0]    cos_o
);

  localparam int CW = gcb_pkg::CS_W;
  localparam longint ONE_DEG = longint'(1) << ANGLE_FRACTION_BITS;
  localparam logic signed [AW-1:0] DEG90  = AW'(90 * ONE_DEG);
  localparam logic signed [AW-1:0] DEG180 = AW'(180 * ONE_DEG);
  localparam logic signed [CW-1:0] X0     = CW'(gcb_pkg::gain_k(CORDIC_STAGES));
  localparam logic signed [CW-1:0] ONE    = CW'(longint'(1) << gcb_pkg::VEC_FRAC);

  logic signed [AW-1:0] z0_r;
  logic                 flip0_r;
  logic signed [AW-1:0] z0_nxt;
  logic                 flip0_nxt;

  logic signed [CW-1:0] x_r [CORDIC_STAGES];
  logic signed [CW-1:0] y_r [CORDIC_STAGES];
  logic signed [AW-1:0] z_r [CORDIC_STAGES];
  logic                 flip_r [CORDIC_STAGES];
  logic                 zero_r [CORDIC_STAGES];
  logic signed [CW-1:0] sin_r;
  logic signed [CW-1:0] cos_r;

  always_comb begin
    z0_nxt    = ang;
    flip0_nxt = 1'b0;
    if (ang > DEG90) begin
      z0_nxt    = DEG180 - ang;
      flip0_nxt = 1'b1;
    end else if (ang < -DEG90) begin
      z0_nxt    = -DEG180 - ang;
      flip0_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      z0_r    <= z0_nxt;
      flip0_r <= flip0_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [AW-1:0] STEP = AW'(gcb_pkg::step_angle(i, ANGLE_FRACTION_BITS));
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [AW-1:0] z_in;
    logic                 flip_in;
    logic                 zero_in;

    if (i == 0) begin : g_first
      assign x_in    = X0;
      assign y_in    = '0;
      assign z_in    = z0_r;
      assign flip_in = flip0_r;
      assign zero_in = (z0_r == '0);
    end else begin : g_next
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
      assign flip_in = flip_r[i-1];
      assign zero_in = zero_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        if (z_in >= 0) begin
          x_r[i] <= x_in - (y_in >>> i);
          y_r[i] <= y_in + (x_in >>> i);
          z_r[i] <= z_in - STEP;
        end else begin
          x_r[i] <= x_in + (y_in >>> i);
          y_r[i] <= y_in - (x_in >>> i);
          z_r[i] <= z_in + STEP;
        end
        flip_r[i] <= flip_in;
        zero_r[i] <= zero_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (zero_r[CORDIC_STAGES-1]) begin
        sin_r <= '0;
        cos_r <= flip_r[CORDIC_STAGES-1] ? -ONE : ONE;
      end else begin
        sin_r <= y_r[CORDIC_STAGES-1];
        cos_r <= flip_r[CORDIC_STAGES-1] ? -x_r[CORDIC_STAGES-1] : x_r[CORDIC_STAGES-1];
      end
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

@@ rtl/great_circle_bearing_deg.sv @@
// great_circle_bearing_deg: initial great-circle bearing between two positions, whole degrees
// depends on gcb_pkg, gcb_to_angle and gcb_cordic_rot
//
// usage:
//   input stream (in_*): one transaction carries a start and a target position, latitude
//   and longitude in signed units of 1e-7 degree. output stream (out_*): one transaction
//   per input, the bearing clockwise from north, 0 to 359, in input order.
//   pipeline: the six-stage unit conversion (reciprocal multiplication and one
//   correction), two cordic pipelines (rotation and vectoring) and the multiply stages.
//   throughput: one transaction per cycle unless backpressure holds the pipeline, fully pipelined.
//   backpressure: the whole pipeline holds while a result sits in the output register
//   and out_tready is low; in_tready drops in that cycle, nothing is lost or repeated.
//   bubbles in the pipeline do not block new inputs while the output is free.
//   reset: rst_n low clears all valid bits, no results come out; the block is stateless
//   apart from the pipeline and needs no warm-up.

module great_circle_bearing_deg #(
  parameter int CORDIC_STAGES = 24,
  parameter int ANGLE_FRACTION_BITS = 28
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // from_lat[30:0], from_lon[62:31], to_lat[93:63], to_lon[125:94]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata   // bearing_deg[8:0]
);

  localparam int AW = ANGLE_FRACTION_BITS + 11;
  localparam int CW = gcb_pkg::CS_W;
  localparam int VW = gcb_pkg::VEC_W;
  localparam int CONV_LAT = 6;
  localparam int LAT = CONV_LAT + 2 * CORDIC_STAGES + 9;
  localparam int CO_LEN = CORDIC_STAGES + 6;
  localparam longint ONE_DEG = longint'(1) << ANGLE_FRACTION_BITS;
  localparam logic signed [AW-1:0] DEG90  = AW'(90 * ONE_DEG);
  localparam logic signed [AW-1:0] DEG180 = AW'(180 * ONE_DEG);
  localparam logic signed [AW-1:0] DEG360 = AW'(360 * ONE_DEG);

  logic ce;
  logic vld_r [LAT];

  logic signed [gcb_pkg::COORD_W-1:0] from_lat;
  logic signed [gcb_pkg::COORD_W-1:0] from_lon;
  logic signed [gcb_pkg::COORD_W-1:0] to_lat;
  logic signed [gcb_pkg::COORD_W-1:0] to_lon;
  logic signed [AW-1:0] a_flat;
  logic signed [AW-1:0] a_flon;
  logic signed [AW-1:0] a_tlat;
  logic signed [AW-1:0] a_tlon;

  logic signed [AW-1:0] lat1_b_r;
  logic signed [AW-1:0] lat2_b_r;
  logic signed [AW-1:0] dsum_r;
  logic signed [AW-1:0] lat1_c_r;
  logic signed [AW-1:0] lat2_c_r;
  logic signed [AW-1:0] dl_r;
  logic signed [AW-1:0] dl_nxt;
  logic                 co_r [CO_LEN];

  logic signed [CW-1:0] s1;
  logic signed [CW-1:0] c1;
  logic signed [CW-1:0] s2;
  logic signed [CW-1:0] c2;
  logic signed [CW-1:0] sd;
  logic signed [CW-1:0] cd;

  logic signed [CW-1:0] ys_r;
  logic signed [CW-1:0] p1_r;
  logic signed [CW-1:0] p2_r;
  logic signed [CW-1:0] cd_m1_r;
  logic signed [CW-1:0] ys_m2_r;
  logic signed [CW-1:0] p1_m2_r;
  logic signed [CW-1:0] p3_r;
  logic signed [VW-1:0] xs_r;
  logic signed [VW-1:0] ys_m3_r;

  logic signed [VW-1:0] vx0_r;
  logic signed [VW-1:0] vy0_r;
  logic signed [AW-1:0] vz0_r;
  logic                 skip0_r;
  logic signed [VW-1:0] vx0_nxt;
  logic signed [VW-1:0] vy0_nxt;
  logic signed [AW-1:0] vz0_nxt;
  logic                 skip0_nxt;

  logic signed [VW-1:0] vx_r [CORDIC_STAGES];
  logic signed [VW-1:0] vy_r [CORDIC_STAGES];
  logic signed [AW-1:0] vz_r [CORDIC_STAGES];
  logic                 skip_r [CORDIC_STAGES];

  logic signed [AW-1:0] z_fin;
  logic [AW-1:0]        z_mag;
  logic [8:0]           t_whole;
  logic [8:0]           bear_nxt;
  logic [8:0]           bear_r;

  // pipeline moves unless a result waits in the output register and out_tready is low
  assign ce        = !vld_r[LAT-1] || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  assign from_lat = {in_tdata[30], in_tdata[30:0]};
  assign from_lon = in_tdata[62:31];
  assign to_lat   = {in_tdata[93], in_tdata[93:63]};
  assign to_lon   = in_tdata[125:94];

  gcb_to_angle #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .AW(AW)) u_conv_flat (
    .clk(clk), .ce(ce), .v(from_lat), .a(a_flat));
  gcb_to_angle #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .AW(AW)) u_conv_flon (
    .clk(clk), .ce(ce), .v(from_lon), .a(a_flon));
  gcb_to_angle #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .AW(AW)) u_conv_tlat (
    .clk(clk), .ce(ce), .v(to_lat), .a(a_tlat));
  gcb_to_angle #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS), .AW(AW)) u_conv_tlon (
    .clk(clk), .ce(ce), .v(to_lon), .a(a_tlon));

  // latitudes stay within about 107 degrees, so only the longitude difference wraps
  always_comb begin
    dl_nxt = dsum_r;
    if (dsum_r > DEG180) dl_nxt = dsum_r - DEG360;
    else if (dsum_r <= -DEG180) dl_nxt = dsum_r + DEG360;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lat1_b_r <= a_flat;
      lat2_b_r <= a_tlat;
      dsum_r   <= a_tlon - a_flon;
      lat1_c_r <= lat1_b_r;
      lat2_c_r <= lat2_b_r;
      dl_r     <= dl_nxt;
      co_r[0]  <= (lat1_b_r == lat2_b_r) && (dl_nxt == '0);
      for (int k = 1; k < CO_LEN; k++) co_r[k] <= co_r[k-1];
    end
  end

  gcb_cordic_rot #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
                   .AW(AW)) u_rot_lat1 (
    .clk(clk), .ce(ce), .ang(lat1_c_r), .sin_o(s1), .cos_o(c1));
  gcb_cordic_rot #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
                   .AW(AW)) u_rot_lat2 (
    .clk(clk), .ce(ce), .ang(lat2_c_r), .sin_o(s2), .cos_o(c2));
  gcb_cordic_rot #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
                   .AW(AW)) u_rot_dlon (
    .clk(clk), .ce(ce), .ang(dl_r), .sin_o(sd), .cos_o(cd));

  // east and north arguments of atan2
  always_ff @(posedge clk) begin
    if (ce) begin
      ys_r    <= gcb_pkg::fmul(sd, c2);
      p1_r    <= gcb_pkg::fmul(c1, s2);
      p2_r    <= gcb_pkg::fmul(s1, c2);
      cd_m1_r <= cd;
      p3_r    <= gcb_pkg::fmul(p2_r, cd_m1_r);
      ys_m2_r <= ys_r;
      p1_m2_r <= p1_r;
      xs_r    <= VW'(p1_m2_r) - VW'(p3_r);
      ys_m3_r <= VW'(ys_m2_r);
    end
  end

  // axis cases and coinciding positions bypass the vectoring stages
  always_comb begin
    vx0_nxt   = xs_r;
    vy0_nxt   = ys_m3_r;
    vz0_nxt   = '0;
    skip0_nxt = 1'b1;
    priority if (co_r[CO_LEN-1] || (xs_r == '0 && ys_m3_r == '0)) begin
      vz0_nxt = '0;
    end else if (ys_m3_r == '0) begin
      vz0_nxt = (xs_r > 0) ? '0 : DEG180;
    end else if (xs_r == '0) begin
      vz0_nxt = (ys_m3_r > 0) ? DEG90 : -DEG90;
    end else if (xs_r < 0) begin
      vx0_nxt   = -xs_r;
      vy0_nxt   = -ys_m3_r;
      vz0_nxt   = (ys_m3_r >= 0) ? DEG180 : -DEG180;
      skip0_nxt = 1'b0;
    end else begin
      skip0_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      vx0_r   <= vx0_nxt;
      vy0_r   <= vy0_nxt;
      vz0_r   <= vz0_nxt;
      skip0_r <= skip0_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    localparam logic signed [AW-1:0] STEP = AW'(gcb_pkg::step_angle(i, ANGLE_FRACTION_BITS));
    logic signed [VW-1:0] x_in;
    logic signed [VW-1:0] y_in;
    logic signed [AW-1:0] z_in;
    logic                 skip_in;

    if (i == 0) begin : g_first
      assign x_in    = vx0_r;
      assign y_in    = vy0_r;
      assign z_in    = vz0_r;
      assign skip_in = skip0_r;
    end else begin : g_next
      assign x_in    = vx_r[i-1];
      assign y_in    = vy_r[i-1];
      assign z_in    = vz_r[i-1];
      assign skip_in = skip_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        skip_r[i] <= skip_in;
        if (y_in < 0) begin
          vx_r[i] <= x_in - (y_in >>> i);
          vy_r[i] <= y_in + (x_in >>> i);
          vz_r[i] <= skip_in ? z_in : z_in - STEP;
        end else begin
          vx_r[i] <= x_in + (y_in >>> i);
          vy_r[i] <= y_in - (x_in >>> i);
          vz_r[i] <= skip_in ? z_in : z_in + STEP;
        end
      end
    end
  end

  // truncate toward zero, then wrap negative degrees into 0..359
  assign z_fin   = vz_r[CORDIC_STAGES-1];
  assign z_mag   = z_fin[AW-1] ? AW'(-z_fin) : AW'(z_fin);
  assign t_whole = z_mag[ANGLE_FRACTION_BITS +: 9];
  assign bear_nxt = (z_fin[AW-1] && t_whole != '0) ? 9'(10'd360 - 10'(t_whole)) : t_whole;

  always_ff @(posedge clk) begin
    if (ce) bear_r <= bear_nxt;
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {7'b0, bear_r};

endmodule
